@@ rtl/gmt_pkg.sv @@
package gmt_pkg;

    localparam int ID_W     = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_ADD   = 2'd0;
    localparam cmd_t CMD_DEL   = 2'd1;
    localparam cmd_t CMD_FIND  = 2'd2;
    localparam cmd_t CMD_CLEAR = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;

endpackage

@@ rtl/gmt_id_ram.sv @@
module gmt_id_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  gmt_pkg::id_t    wdata,
    input  logic [AW-1:0]   raddr,
    output gmt_pkg::id_t    rdata
);
    import gmt_pkg::*;

    id_t mem [DEPTH];
    id_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/group_membership_table_unit.sv @@
// Group membership table: TABLE_SLOTS slots of 16-bit group ids with a valid bit per slot.
// An item is taken when start is high and busy is low; it carries command and grp_id.
// Commands: add stores the id in the lowest free slot, delete clears the lowest valid slot
// holding the id, find looks the id up, and clear drops every valid bit.
// Every item yields exactly one result: done is high for one cycle with status on the port.
// The receiver cannot stall; each result is taken in the cycle that done is high.
// Slot ids live in a synchronous memory with one read port; delete and find walk it one slot
// per cycle behind a registered read, and stop at the first valid slot holding the id or
// report not found after the last slot.
// Add walks the valid bits one slot per cycle: it stores the id in the lowest free slot,
// or reports full when the last slot is valid as well.
// Clear shows done in the cycle after it is taken. An item may be taken in the cycle its
// predecessor shows done. The scan walks the slots in order, so a scanning item holds the
// block busy until its result shows; a clear never raises busy.
// Reset empties the valid map and drops any item in flight; the memory needs no clearing.
module group_membership_table_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gmt_pkg::cmd_t      command,
    input  gmt_pkg::id_t       grp_id,
    output logic               done,
    output gmt_pkg::status_t   status
);
    import gmt_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                   state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    id_t                    id_reg, id_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;

    logic [IDX_W-1:0]       scan_idx;
    logic                   ram_we;
    id_t                    ram_rdata;

    assign scan_idx = cnt_reg[IDX_W-1:0];

    gmt_id_ram #(
        .DEPTH (TABLE_SLOTS),
        .AW    (IDX_W)
    ) u_id_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_idx),
        .wdata (id_reg),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        valid_next     = valid_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    id_next  = grp_id;
                    cnt_next = '0;
                    if (command == CMD_CLEAR)
                    begin
                        valid_next  = '0;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!valid_reg[scan_idx])
                        begin
                            ram_we               = 1'b1;
                            valid_next[scan_idx] = 1'b1;
                            done_next            = 1'b1;
                            status_next          = ST_OK;
                            state_next           = S_IDLE;
                        end
                        else if (scan_idx == LAST_IDX)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (cnt_reg != SLOTS_CNT)
                        begin
                            cmp_valid_next = 1'b1;
                            cmp_idx_next   = scan_idx;
                            cnt_next       = cnt_reg + 1'b1;
                        end
                        if (cmp_valid_reg)
                        begin
                            if (valid_reg[cmp_idx_reg] && (ram_rdata == id_reg))
                            begin
                                if (cmd_reg == CMD_DEL)
                                begin
                                    valid_next[cmp_idx_reg] = 1'b0;
                                end
                                cmp_valid_next = 1'b0;
                                done_next      = 1'b1;
                                status_next    = ST_OK;
                                state_next     = S_IDLE;
                            end
                            else if (cmp_idx_reg == LAST_IDX)
                            begin
                                cmp_valid_next = 1'b0;
                                done_next      = 1'b1;
                                status_next    = ST_NOTFOUND;
                                state_next     = S_IDLE;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            valid_reg     <= valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule
